// File: src/gamepad_report_conditioner_assert.svh
// assertion macros for the gamepad report conditioner
`ifndef GAMEPAD_REPORT_CONDITIONER_ASSERT_SVH
`define GAMEPAD_REPORT_CONDITIONER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GPC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("gpc assertion failed");
`define GPC_ASSERT_IMPL(lbl, ante, cons) `GPC_ASSERT(lbl, (ante) |-> (cons))
`else
`define GPC_ASSERT(lbl, prop)
`define GPC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: src/gpc_pkg.sv
// shared types, constants and button remap for the gamepad report conditioner
`timescale 1ns / 1ps
`default_nettype none
package gpc_pkg;

  localparam int PAD_COUNT = 4;
  localparam int PAD_IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8269;
  localparam logic [7:0]  TRIG_DZ_RST  = 8'd30;
  localparam logic [14:0] LIMIT_RST    = 15'd32767;

  localparam int SQRT_STEPS = 16;
  localparam int QUO_W      = 17;
  localparam int QCNT_W     = $clog2(QUO_W);

  typedef enum logic [1:0] {
    REG_LEFT_DZ  = 2'd0,
    REG_RIGHT_DZ = 2'd1,
    REG_TRIG_DZ  = 2'd2,
    REG_LIMIT    = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MAG,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_DZ,
    ST_CMP,
    ST_SQRT,
    ST_LIMIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TRIG_GO,
    ST_TRIG_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_COMMIT,
    OP_DROP,
    OP_MAG,
    OP_MUL_X,
    OP_MUL_Y,
    OP_MUL_DZ,
    OP_STICK_ZERO,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_LIMIT,
    OP_DIV_START,
    OP_STICK_STORE,
    OP_TRIG_START,
    OP_TRIG_STORE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic stick;     // 0 left, 1 right
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pad_ok;
    logic present;
    logic pkt_same;
    logic pad_conn;
    logic dead;
    logic div_busy;
    logic out_free;
  } stat_t;

  function automatic logic [13:0] remap_buttons(input logic [15:0] w);
    remap_buttons = {w[7], w[6], w[9], w[8], w[5], w[4], w[14], w[13],
                     w[12], w[15], w[2], w[3], w[1], w[0]};
  endfunction

endpackage
`default_nettype wire

// File: src/gpc_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module gpc_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                num_i,
  input  wire logic [14:0]                den_i,
  output logic                            busy_o,
  output logic [gpc_pkg::QUO_W-1:0]       quo_o
);

  logic [15:0]                    rem_q;
  logic [gpc_pkg::QUO_W-1:0]      lo_q, quo_q;
  logic [14:0]                    den_q;
  logic [gpc_pkg::QCNT_W-1:0]     cnt_q;
  logic                           busy_q;
  logic [16:0]                    trial;
  logic                           ge;

  assign trial = {rem_q, lo_q[gpc_pkg::QUO_W-1]};
  assign ge    = trial >= {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == gpc_pkg::QCNT_W'(gpc_pkg::QUO_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[31:17]};
      lo_q  <= num_i[gpc_pkg::QUO_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 16'(trial - {2'b00, den_q}) : trial[15:0];
      lo_q  <= {lo_q[gpc_pkg::QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[gpc_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: src/gpc_ctrl.sv
// sequencer for lookup, stick and trigger conditioning
`timescale 1ns / 1ps
`default_nettype none
`include "gamepad_report_conditioner_assert.svh"
module gpc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire gpc_pkg::stat_t stat_i,
  output gpc_pkg::cmd_t       cmd_o
);

  gpc_pkg::state_e state_q, state_d;
  logic            stick_q, stick_d;
  logic [3:0]      cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpc_pkg::ST_IDLE;
      stick_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      stick_q <= stick_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    stick_d          = stick_q;
    cnt_d            = cnt_q;
    cmd_o.op         = gpc_pkg::OP_NONE;
    cmd_o.stick      = stick_q;
    cmd_o.load_out   = 1'b0;
    in_stall_o       = (state_q != gpc_pkg::ST_IDLE);
    unique case (state_q)
      gpc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = gpc_pkg::OP_CAPTURE;
          state_d  = gpc_pkg::ST_LOOKUP;
        end
      end
      gpc_pkg::ST_LOOKUP: begin
        stick_d = 1'b0;
        if (!stat_i.pad_ok) begin
          state_d = gpc_pkg::ST_IDLE;
        end else if (stat_i.present && !stat_i.pkt_same) begin
          cmd_o.op = gpc_pkg::OP_COMMIT;
          state_d  = gpc_pkg::ST_MAG;
        end else if (!stat_i.present && stat_i.pad_conn) begin
          cmd_o.op = gpc_pkg::OP_DROP;
          state_d  = gpc_pkg::ST_DONE;
        end else begin
          state_d = gpc_pkg::ST_IDLE;
        end
      end
      gpc_pkg::ST_MAG: begin
        cmd_o.op = gpc_pkg::OP_MAG;
        state_d  = gpc_pkg::ST_MUL_X;
      end
      gpc_pkg::ST_MUL_X: begin
        cmd_o.op = gpc_pkg::OP_MUL_X;
        state_d  = gpc_pkg::ST_MUL_Y;
      end
      gpc_pkg::ST_MUL_Y: begin
        cmd_o.op = gpc_pkg::OP_MUL_Y;
        state_d  = gpc_pkg::ST_MUL_DZ;
      end
      gpc_pkg::ST_MUL_DZ: begin
        cmd_o.op = gpc_pkg::OP_MUL_DZ;
        state_d  = gpc_pkg::ST_CMP;
      end
      gpc_pkg::ST_CMP: begin
        if (stat_i.dead) begin
          cmd_o.op = gpc_pkg::OP_STICK_ZERO;
          if (stick_q) begin
            state_d = gpc_pkg::ST_TRIG_GO;
          end else begin
            stick_d = 1'b1;
            state_d = gpc_pkg::ST_MAG;
          end
        end else begin
          cmd_o.op = gpc_pkg::OP_SQRT_INIT;
          cnt_d    = '0;
          state_d  = gpc_pkg::ST_SQRT;
        end
      end
      gpc_pkg::ST_SQRT: begin
        cmd_o.op = gpc_pkg::OP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 4'(gpc_pkg::SQRT_STEPS - 1)) begin
          state_d = gpc_pkg::ST_LIMIT;
        end
      end
      gpc_pkg::ST_LIMIT: begin
        cmd_o.op = gpc_pkg::OP_LIMIT;
        state_d  = gpc_pkg::ST_DIV_GO;
      end
      gpc_pkg::ST_DIV_GO: begin
        cmd_o.op = gpc_pkg::OP_DIV_START;
        state_d  = gpc_pkg::ST_DIV_WAIT;
      end
      gpc_pkg::ST_DIV_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = gpc_pkg::OP_STICK_STORE;
          if (stick_q) begin
            state_d = gpc_pkg::ST_TRIG_GO;
          end else begin
            stick_d = 1'b1;
            state_d = gpc_pkg::ST_MAG;
          end
        end
      end
      gpc_pkg::ST_TRIG_GO: begin
        cmd_o.op = gpc_pkg::OP_TRIG_START;
        state_d  = gpc_pkg::ST_TRIG_WAIT;
      end
      gpc_pkg::ST_TRIG_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = gpc_pkg::OP_TRIG_STORE;
          state_d  = gpc_pkg::ST_DONE;
        end
      end
      gpc_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = gpc_pkg::ST_IDLE;
        end
      end
      default: state_d = gpc_pkg::ST_IDLE;
    endcase
  end

  `GPC_ASSERT(a_div_runs, (state_q == gpc_pkg::ST_DIV_GO) |=> stat_i.div_busy)
  `GPC_ASSERT_IMPL(a_done_from_wait, (state_q == gpc_pkg::ST_DONE) && !stat_i.out_free, state_d == gpc_pkg::ST_DONE)

endmodule
`default_nettype wire

// File: src/gpc_dp.sv
// datapath: pad state, config, multiplier, root, dividers, result registers
`timescale 1ns / 1ps
`default_nettype none
module gpc_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gpc_pkg::cmd_t       cmd_i,
  output gpc_pkg::stat_t           stat_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [14:0]         cfg_data_i,
  input  wire logic [1:0]          pad_index_i,
  input  wire logic                present_i,
  input  wire logic [31:0]         packet_number_i,
  input  wire logic [15:0]         raw_buttons_i,
  input  wire logic signed [15:0]  left_x_i,
  input  wire logic signed [15:0]  left_y_i,
  input  wire logic signed [15:0]  right_x_i,
  input  wire logic signed [15:0]  right_y_i,
  input  wire logic [7:0]          left_pull_i,
  input  wire logic [7:0]          right_pull_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic [1:0]               out_pad_o,
  output logic                     connected_o,
  output logic [13:0]              buttons_o,
  output logic signed [15:0]       left_stick_x_o,
  output logic signed [15:0]       left_stick_y_o,
  output logic signed [15:0]       right_stick_x_o,
  output logic signed [15:0]       right_stick_y_o,
  output logic [15:0]              left_trigger_o,
  output logic [15:0]              right_trigger_o
);

  localparam int PW = gpc_pkg::PAD_IDX_W;

  // config
  logic [14:0] left_dz_q, right_dz_q, limit_q;
  logic [7:0]  trig_dz_q;

  // pad state
  logic [31:0]               last_pkt_q [gpc_pkg::PAD_COUNT];
  logic [gpc_pkg::PAD_COUNT-1:0] conn_q;

  // captured item
  logic [1:0]         pad_q;
  logic               pres_q;
  logic [31:0]        pkt_q;
  logic [15:0]        btn_q;
  logic signed [15:0] lx_q, ly_q, rx_q, ry_q;
  logic [7:0]         lp_q, rp_q;

  // stick arithmetic
  logic [16:0] ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [31:0] prod_q, sum_q;
  logic [31:0] v_q, root_q, bit_q;
  logic [14:0] m_q;
  logic        ovx_q, ovy_q, tzl_q, tzr_q;

  // results
  logic               res_conn_q;
  logic [13:0]        res_btn_q;
  logic signed [15:0] res_lx_q, res_ly_q, res_rx_q, res_ry_q;
  logic [15:0]        res_lt_q, res_rt_q;
  logic               out_valid_q;

  logic [PW-1:0]      idx;
  logic signed [15:0] sx, sy;
  logic [14:0]        dz;
  logic [16:0]        mul_a, mul_b;
  logic [31:0]        mul_p;
  logic [31:0]        rb;
  logic [14:0]        lim;
  logic [14:0]        mclip;
  logic               div_start;
  logic [31:0]        num_a, num_b;
  logic [14:0]        den;
  logic               busy_a, busy_b;
  logic [gpc_pkg::QUO_W-1:0] quo_a, quo_b;
  logic [15:0]        satx, saty, tl, tr;
  logic [7:0]         tden;

  assign idx = PW'(pad_q);
  assign sx  = cmd_i.stick ? rx_q : lx_q;
  assign sy  = cmd_i.stick ? ry_q : ly_q;
  assign dz  = cmd_i.stick ? right_dz_q : left_dz_q;

  always_comb begin
    unique case (cmd_i.op)
      gpc_pkg::OP_MUL_X: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      gpc_pkg::OP_MUL_Y: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      default: begin
        mul_a = {2'b00, dz};
        mul_b = {2'b00, dz};
      end
    endcase
  end
  assign mul_p = 32'(mul_a * mul_b);

  assign rb    = root_q + bit_q;
  assign lim   = (limit_q == '0) ? 15'd1 : limit_q;
  assign mclip = (root_q > {17'd0, lim}) ? lim :
                 ((root_q == '0) ? 15'd1 : root_q[14:0]);

  assign tden      = 8'd255 - trig_dz_q;
  assign div_start = (cmd_i.op == gpc_pkg::OP_DIV_START) ||
                     (cmd_i.op == gpc_pkg::OP_TRIG_START);
  always_comb begin
    if (cmd_i.op == gpc_pkg::OP_TRIG_START) begin
      num_a = {8'd0, 8'(lp_q - trig_dz_q), 16'd0};
      num_b = {8'd0, 8'(rp_q - trig_dz_q), 16'd0};
      den   = {7'd0, tden};
    end else begin
      num_a = {ax_q, 15'd0};
      num_b = {ay_q, 15'd0};
      den   = m_q;
    end
  end

  gpc_div u_div_a (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_a), .den_i(den),
    .busy_o(busy_a), .quo_o(quo_a)
  );
  gpc_div u_div_b (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_b), .den_i(den),
    .busy_o(busy_b), .quo_o(quo_b)
  );

  // Q1.15 saturation toward the sign of the raw axis
  always_comb begin
    if (negx_q) begin
      satx = (ovx_q || quo_a > 17'd32768) ? 16'h8000 : 16'(~quo_a + 17'd1);
    end else begin
      satx = (ovx_q || quo_a > 17'd32767) ? 16'h7fff : quo_a[15:0];
    end
    if (negy_q) begin
      saty = (ovy_q || quo_b > 17'd32768) ? 16'h8000 : 16'(~quo_b + 17'd1);
    end else begin
      saty = (ovy_q || quo_b > 17'd32767) ? 16'h7fff : quo_b[15:0];
    end
    tl = tzl_q ? 16'd0 : (quo_a[16] ? 16'hffff : quo_a[15:0]);
    tr = tzr_q ? 16'd0 : (quo_b[16] ? 16'hffff : quo_b[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q  <= gpc_pkg::LEFT_DZ_RST;
      right_dz_q <= gpc_pkg::RIGHT_DZ_RST;
      trig_dz_q  <= gpc_pkg::TRIG_DZ_RST;
      limit_q    <= gpc_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (gpc_pkg::reg_idx_e'(cfg_idx_i))
        gpc_pkg::REG_LEFT_DZ:  left_dz_q  <= cfg_data_i;
        gpc_pkg::REG_RIGHT_DZ: right_dz_q <= cfg_data_i;
        gpc_pkg::REG_TRIG_DZ:  trig_dz_q  <= cfg_data_i[7:0];
        gpc_pkg::REG_LIMIT:    limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gpc_pkg::PAD_COUNT; i++) begin
        last_pkt_q[i] <= '0;
      end
      conn_q <= '0;
    end else if (cmd_i.op == gpc_pkg::OP_COMMIT) begin
      last_pkt_q[idx] <= pkt_q;
      conn_q[idx]     <= 1'b1;
    end else if (cmd_i.op == gpc_pkg::OP_DROP) begin
      conn_q[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gpc_pkg::OP_CAPTURE: begin
        pad_q  <= pad_index_i;
        pres_q <= present_i;
        pkt_q  <= packet_number_i;
        btn_q  <= raw_buttons_i;
        lx_q   <= left_x_i;
        ly_q   <= left_y_i;
        rx_q   <= right_x_i;
        ry_q   <= right_y_i;
        lp_q   <= left_pull_i;
        rp_q   <= right_pull_i;
      end
      gpc_pkg::OP_COMMIT: begin
        res_conn_q <= 1'b1;
        res_btn_q  <= gpc_pkg::remap_buttons(btn_q);
      end
      gpc_pkg::OP_DROP: begin
        res_conn_q <= 1'b0;
        res_btn_q  <= '0;
        res_lx_q   <= '0;
        res_ly_q   <= '0;
        res_rx_q   <= '0;
        res_ry_q   <= '0;
        res_lt_q   <= '0;
        res_rt_q   <= '0;
      end
      gpc_pkg::OP_MAG: begin
        negx_q <= sx[15];
        negy_q <= sy[15];
        ax_q   <= sx[15] ? 17'(-{sx[15], sx}) : {1'b0, sx};
        ay_q   <= sy[15] ? 17'(-{sy[15], sy}) : {1'b0, sy};
      end
      gpc_pkg::OP_MUL_X: prod_q <= mul_p;
      gpc_pkg::OP_MUL_Y: begin
        sum_q  <= prod_q;
        prod_q <= mul_p;
      end
      gpc_pkg::OP_MUL_DZ: begin
        sum_q  <= sum_q + prod_q;
        prod_q <= mul_p;
      end
      gpc_pkg::OP_STICK_ZERO: begin
        if (cmd_i.stick) begin
          res_rx_q <= '0;
          res_ry_q <= '0;
        end else begin
          res_lx_q <= '0;
          res_ly_q <= '0;
        end
      end
      gpc_pkg::OP_SQRT_INIT: begin
        v_q    <= sum_q;
        root_q <= '0;
        bit_q  <= 32'h4000_0000;
      end
      gpc_pkg::OP_SQRT_STEP: begin
        if (v_q >= rb) begin
          v_q    <= v_q - rb;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      gpc_pkg::OP_LIMIT: m_q <= mclip;
      gpc_pkg::OP_DIV_START: begin
        ovx_q <= ax_q >= {m_q, 2'b00};
        ovy_q <= ay_q >= {m_q, 2'b00};
      end
      gpc_pkg::OP_STICK_STORE: begin
        if (cmd_i.stick) begin
          res_rx_q <= satx;
          res_ry_q <= saty;
        end else begin
          res_lx_q <= satx;
          res_ly_q <= saty;
        end
      end
      gpc_pkg::OP_TRIG_START: begin
        tzl_q <= (lp_q <= trig_dz_q) || (trig_dz_q == 8'd255);
        tzr_q <= (rp_q <= trig_dz_q) || (trig_dz_q == 8'd255);
      end
      gpc_pkg::OP_TRIG_STORE: begin
        res_lt_q <= tl;
        res_rt_q <= tr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_pad_o       <= pad_q;
      connected_o     <= res_conn_q;
      buttons_o       <= res_btn_q;
      left_stick_x_o  <= res_lx_q;
      left_stick_y_o  <= res_ly_q;
      right_stick_x_o <= res_rx_q;
      right_stick_y_o <= res_ry_q;
      left_trigger_o  <= res_lt_q;
      right_trigger_o <= res_rt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.pad_ok   = 32'(pad_q) < 32'(gpc_pkg::PAD_COUNT);
  assign stat_o.present  = pres_q;
  assign stat_o.pkt_same = last_pkt_q[idx] == pkt_q;
  assign stat_o.pad_conn = conn_q[idx];
  assign stat_o.dead     = sum_q <= prod_q;
  assign stat_o.div_busy = busy_a || busy_b;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

// File: src/gamepad_report_conditioner.sv
// top level of the gamepad report conditioner
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o    pad, present, packet, buttons, sticks, pulls
//  out       output     out_valid_o / out_stall_i  pad, connected, buttons, sticks, triggers
//  cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  no result: lookup, then idle again; disconnect: lookup, drop, then result valid
//  conditioned: per stick magnitude, square x, square y, square dead zone and compare,
//  then outside the dead zone 16 root steps, limit, start, 17 divide steps, store;
//  triggers add start, divide and store; done by the serial root and the two one-bit-per-cycle dividers
//  reset clears pad state and loads register defaults; no clearing pass
//  a stalled result is held in the output register while the next item waits
`timescale 1ns / 1ps
`default_nettype none
`include "gamepad_report_conditioner_assert.svh"
module gamepad_report_conditioner (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [14:0]         cfg_data_i,
  // input items
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          pad_index_i,
  input  wire logic                present_i,
  input  wire logic [31:0]         packet_number_i,
  input  wire logic [15:0]         raw_buttons_i,
  input  wire logic signed [15:0]  left_x_i,
  input  wire logic signed [15:0]  left_y_i,
  input  wire logic signed [15:0]  right_x_i,
  input  wire logic signed [15:0]  right_y_i,
  input  wire logic [7:0]          left_pull_i,
  input  wire logic [7:0]          right_pull_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               out_pad_o,
  output logic                     connected_o,
  output logic [13:0]              buttons_o,
  output logic signed [15:0]       left_stick_x_o,
  output logic signed [15:0]       left_stick_y_o,
  output logic signed [15:0]       right_stick_x_o,
  output logic signed [15:0]       right_stick_y_o,
  output logic [15:0]              left_trigger_o,
  output logic [15:0]              right_trigger_o
);

  // command and status between sequencer and datapath
  gpc_pkg::cmd_t  cmd;
  gpc_pkg::stat_t stat;

  gpc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  gpc_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .pad_index_i,
    .present_i,
    .packet_number_i,
    .raw_buttons_i,
    .left_x_i,
    .left_y_i,
    .right_x_i,
    .right_y_i,
    .left_pull_i,
    .right_pull_i,
    .out_stall_i,
    .out_valid_o,
    .out_pad_o,
    .connected_o,
    .buttons_o,
    .left_stick_x_o,
    .left_stick_y_o,
    .right_stick_x_o,
    .right_stick_y_o,
    .left_trigger_o,
    .right_trigger_o
  );

  // one item in flight: after an accept the input side stalls
  `GPC_ASSERT(a_in_one, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // a disconnect result carries only cleared fields
  `GPC_ASSERT_IMPL(a_drop_clear, out_valid_o && !connected_o, (buttons_o == '0) && (left_stick_x_o == '0) && (left_stick_y_o == '0) && (right_stick_x_o == '0) && (right_stick_y_o == '0) && (left_trigger_o == '0) && (right_trigger_o == '0))

endmodule
`default_nettype wire
